// ----- rtl/core/ptt_pkg.sv -----
// Shared constants and codes for the periodic timer table.
package ptt_pkg;

    localparam int TIMERS_DEFAULT = 16;

    localparam int OPCODE_W   = 2;
    localparam int ID_W       = 4;
    localparam int INTERVAL_W = 32;
    localparam int TIME_W     = 48;
    localparam int STATUS_W   = 3;
    localparam int PERIOD_W   = 42;   // interval_ms * 1000 stays below 2^42

    localparam logic [9:0] USEC_PER_MS = 10'd1000;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ARMED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ARMED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIRED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE_FIRED = 3'd5;

endpackage

// ----- rtl/core/ptt_req_if.sv -----
// Request channel of the periodic timer table.
interface ptt_req_if;
    logic                               valid;
    logic                               ready;
    logic [ptt_pkg::OPCODE_W-1:0]       opcode;
    logic [ptt_pkg::ID_W-1:0]           timer_id;
    logic [ptt_pkg::INTERVAL_W-1:0]     interval_ms;
    logic [ptt_pkg::TIME_W-1:0]         now_us;

    modport source (output valid, opcode, timer_id, interval_ms, now_us, input ready);
    modport sink   (input valid, opcode, timer_id, interval_ms, now_us, output ready);
endinterface

// ----- rtl/core/ptt_rsp_if.sv -----
// Response channel of the periodic timer table.
interface ptt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ptt_pkg::STATUS_W-1:0]   status;
    logic [ptt_pkg::ID_W-1:0]       fired_id;
    logic                           last;

    modport source (output valid, status, fired_id, last, input ready);
    modport sink   (input valid, status, fired_id, last, output ready);
endinterface

// ----- rtl/core/periodic_timer_table.sv -----
// Periodic timer table: TIMERS slots scanned one at a time by a shared datapath.
//
// req carries add, remove and tick requests; rsp returns results, with last
// set on the final result of each request. cfg_we/cfg_wdata write timer_mode
// (0 absolute, 1 relative); the user must do so only while the block is idle,
// as the block itself does not enforce it. Add and remove answer with one
// result, registered in the cycle after accept. A tick taken in S_IDLE walks
// the slots in id order through one multiply/subtract/compare unit: an idle
// slot passes through S_READ only, an armed one through S_READ, S_CALC and
// S_UPD, and S_FLUSH closes the scan. A firing is held back one step so that
// last can be set on the final one; a tick with no firing answers "none".
// One request is in flight at a time; req.ready is low during a scan.
// A single output register decouples rsp: when rsp stalls, the scan waits at
// the next firing until the register drains, so no result is dropped.
// Reset clears all armed flags, the mode and the output valid flag; period and
// start storage is not cleared and is used only for armed slots.
module periodic_timer_table #(
    parameter int TIMERS = ptt_pkg::TIMERS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    ptt_req_if.sink       req,
    ptt_rsp_if.source     rsp,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import ptt_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TIMERS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CALC  = 5'b00100,
        S_UPD   = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [TIMERS-1:0]      armed_reg, armed_next;
    logic                   mode_reg;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]        pend_id_reg, pend_id_next;

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic                   out_last_reg;
    logic                   out_free;

    logic                   push;
    logic [STATUS_W-1:0]    push_status;
    logic [ID_W-1:0]        push_id;
    logic                   push_last;

    logic [INTERVAL_W-1:0]  period_mem [TIMERS];
    logic [TIME_W-1:0]      start_mem  [TIMERS];
    logic [INTERVAL_W-1:0]  rd_period_reg;
    logic [TIME_W-1:0]      rd_start_reg;
    logic                   start_we, period_we;
    logic [IW-1:0]          mem_addr;
    logic [TIME_W-1:0]      wr_start;

    logic [PERIOD_W-1:0]    period_us_reg;
    logic [TIME_W-1:0]      elapsed_reg;

    logic                   id_ok;
    logic [IW-1:0]          id_idx;
    logic                   el_neg, fire, late;
    logic [TIME_W-1:0]      advanced;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;

    assign id_ok  = 32'(req.timer_id) < TIMERS;
    assign id_idx = IW'(req.timer_id);

    // shared compare/advance unit, working on the registered elapsed/period
    assign el_neg   = elapsed_reg[TIME_W-1];
    assign fire     = !el_neg && (elapsed_reg > TIME_W'(period_us_reg));
    assign late     = elapsed_reg > TIME_W'({period_us_reg, 1'b0});
    assign advanced = rd_start_reg + TIME_W'(period_us_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        armed_next      = armed_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        push            = 1'b0;
        push_status     = ST_NONE_FIRED;
        push_id         = '0;
        push_last       = 1'b0;
        start_we        = 1'b0;
        period_we       = 1'b0;
        mem_addr        = idx_reg;
        wr_start        = now_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && out_free)
                begin
                    case (req.opcode)
                        OP_ADD:
                        begin
                            push      = 1'b1;
                            push_id   = req.timer_id;
                            push_last = 1'b1;
                            if (id_ok && !armed_reg[id_idx])
                            begin
                                armed_next[id_idx] = 1'b1;
                                start_we           = 1'b1;
                                period_we          = 1'b1;
                                mem_addr           = id_idx;
                                wr_start           = req.now_us;
                                push_status        = ST_ADDED;
                            end
                            else
                            begin
                                push_status = ST_ARMED;
                            end
                        end
                        OP_REMOVE:
                        begin
                            push      = 1'b1;
                            push_id   = req.timer_id;
                            push_last = 1'b1;
                            if (id_ok && armed_reg[id_idx])
                            begin
                                armed_next[id_idx] = 1'b0;
                                push_status        = ST_REMOVED;
                            end
                            else
                            begin
                                push_status = ST_NOT_ARMED;
                            end
                        end
                        OP_TICK:
                        begin
                            now_next        = req.now_us;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (armed_reg[idx_reg])
                    state_next = S_CALC;
                else if (idx_reg == LAST_IDX)
                    state_next = S_FLUSH;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_CALC:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // a new firing pushes the held one out; wait if rsp is full
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    if (el_neg)
                    begin
                        start_we = 1'b1;
                        wr_start = now_reg;
                    end
                    else if (fire)
                    begin
                        start_we = 1'b1;
                        wr_start = (late || mode_reg) ? now_reg : advanced;
                        if (pend_valid_reg)
                        begin
                            push        = 1'b1;
                            push_status = ST_FIRED;
                            push_id     = pend_id_reg;
                            push_last   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = ID_W'(idx_reg);
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_status = ST_FIRED;
                        push_id     = pend_id_reg;
                    end
                    else
                    begin
                        push_status = ST_NONE_FIRED;
                        push_id     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            armed_reg      <= '0;
            mode_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            armed_reg      <= armed_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (push)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        pend_id_reg <= pend_id_next;
        if (push)
        begin
            out_status_reg <= push_status;
            out_id_reg     <= push_id;
            out_last_reg   <= push_last;
        end
        if (state_reg == S_CALC)
        begin
            period_us_reg <= PERIOD_W'(rd_period_reg) * PERIOD_W'(USEC_PER_MS);
            elapsed_reg   <= now_reg - rd_start_reg;
        end
    end

    // slot storage: one write port, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[mem_addr] <= wr_start;
        if (period_we)
            period_mem[mem_addr] <= req.interval_ms;
        rd_start_reg  <= start_mem[idx_reg];
        rd_period_reg <= period_mem[idx_reg];
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.fired_id = out_id_reg;
    assign rsp.last     = out_last_reg;

endmodule

// ----- tb/timer_result_checker.sv -----
// Result checker for the periodic timer table: tracks the timer slots and compares every response.
`timescale 1ns / 100ps

module timer_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    ptt_req_if          req,
    ptt_rsp_if          rsp,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output int unsigned mismatch_count,
    output int unsigned results_outstanding
);
    import ptt_pkg::*;

    localparam int SLOTS = TIMERS_DEFAULT;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     fired_id;
        logic                last;
    } timer_result_t;

    timer_result_t         expected_results[$];
    timer_result_t         want;
    logic                  relative_mode;
    logic                  slot_armed    [SLOTS];
    logic [INTERVAL_W-1:0] slot_interval [SLOTS];
    logic [TIME_W-1:0]     slot_start    [SLOTS];

    // Updates the slot table for one request and queues the results it must produce.
    function automatic void predict_timer_results(
        input logic [OPCODE_W-1:0]   op,
        input logic [ID_W-1:0]       id,
        input logic [INTERVAL_W-1:0] interval,
        input logic [TIME_W-1:0]     now
    );
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] period_us;
        timer_result_t     held;
        logic              have_held;
        int                slot;

        have_held = 1'b0;
        held      = '0;
        case (op)
            OP_ADD:
            begin
                if (slot_armed[id])
                    expected_results.push_back('{ST_ARMED, id, 1'b1});
                else
                begin
                    slot_armed[id]    = 1'b1;
                    slot_interval[id] = interval;
                    slot_start[id]    = now;
                    expected_results.push_back('{ST_ADDED, id, 1'b1});
                end
            end
            OP_REMOVE:
            begin
                if (slot_armed[id])
                begin
                    slot_armed[id] = 1'b0;
                    expected_results.push_back('{ST_REMOVED, id, 1'b1});
                end
                else
                    expected_results.push_back('{ST_NOT_ARMED, id, 1'b1});
            end
            OP_TICK:
            begin
                for (slot = 0; slot < SLOTS; slot++)
                begin
                    if (slot_armed[slot])
                    begin
                        elapsed = now - slot_start[slot];
                        if (elapsed[TIME_W-1])
                            slot_start[slot] = now;   // clock went backwards
                        else
                        begin
                            period_us = TIME_W'(slot_interval[slot]) * TIME_W'(USEC_PER_MS);
                            if (elapsed > period_us)
                            begin
                                if (elapsed > (period_us << 1) || relative_mode)
                                    slot_start[slot] = now;
                                else
                                    slot_start[slot] = slot_start[slot] + period_us;
                                // hold each firing back one step so the final one gets last
                                if (have_held)
                                    expected_results.push_back(held);
                                held      = '{ST_FIRED, ID_W'(slot), 1'b0};
                                have_held = 1'b1;
                            end
                        end
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    expected_results.push_back(held);
                end
                else
                    expected_results.push_back('{ST_NONE_FIRED, '0, 1'b1});
            end
            default:
            begin
                // unused opcode: no result, no state change
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relative_mode = 1'b0;
            for (int s = 0; s < SLOTS; s++)
                slot_armed[s] = 1'b0;
            expected_results.delete();
            mismatch_count      = 0;
            results_outstanding = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d fired_id %0d last %0d",
                           rsp.status, rsp.fired_id, rsp.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.fired_id !== want.fired_id)
                    begin
                        $error("fired_id: expected %0d, actual %0d",
                               want.fired_id, rsp.fired_id);
                        mismatch_count++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, rsp.last);
                        mismatch_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_timer_results(req.opcode, req.timer_id, req.interval_ms, req.now_us);
            if (cfg_we)
                relative_mode = cfg_wdata;
            results_outstanding = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_periodic_timer_table.sv -----
// Testbench top for the periodic timer table: stimulus, response flow control and verdict.
`timescale 1ns / 100ps

module tb_periodic_timer_table;
    import ptt_pkg::*;

    localparam int          CLK_PERIOD       = 12;
    localparam int          RESET_CYCLES     = 7;
    localparam int          SETTLE_CYCLES    = 64;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int unsigned LIMIT_CYCLES     = 400000;

    localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;
    localparam logic                MODE_ABSOLUTE = 1'b0;
    localparam logic                MODE_RELATIVE = 1'b1;

    localparam logic [TIME_W-1:0]     TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0]     TIME_HALF    = 48'h8000_0000_0000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        idle_on;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned results_outstanding;
    logic [TIME_W-1:0] sim_now;

    ptt_req_if req_ch ();
    ptt_rsp_if rsp_ch ();

    periodic_timer_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    timer_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req                 (req_ch),
        .rsp                 (rsp_ch),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Response side: random stall bursts, plus a long hold on demand.
    initial
    begin
        rsp_ch.ready = 1'b0;
        holds_served = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                holds_served++;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_request(
        input logic [OPCODE_W-1:0]   op,
        input logic [ID_W-1:0]       id,
        input logic [INTERVAL_W-1:0] interval,
        input logic [TIME_W-1:0]     now
    );
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.timer_id    <= id;
        req_ch.interval_ms <= interval;
        req_ch.now_us      <= now;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly a running clock with arms, disarms and ticks; now and then the
    // clock steps back or jumps anywhere in the 48-bit range.
    task automatic random_request(output bit counted);
        logic [OPCODE_W-1:0]   op;
        logic [ID_W-1:0]       id;
        logic [INTERVAL_W-1:0] interval;
        logic [TIME_W-1:0]     stamp;
        int unsigned           pick;

        pick     = $urandom_range(0, 99);
        id       = ID_W'($urandom_range(0, TIMERS_DEFAULT - 1));
        interval = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 20);
        stamp    = {16'($urandom()), $urandom()};
        if (pick < 40)
        begin
            op = OP_TICK;
            case ($urandom_range(0, 19))
                0:       sim_now = sim_now - $urandom_range(1, 8000);
                1:       sim_now = {16'($urandom()), $urandom()};
                default: sim_now = sim_now + $urandom_range(0, 25000);
            endcase
            stamp = sim_now;
        end
        else if (pick < 72)
        begin
            op      = OP_ADD;
            sim_now = sim_now + $urandom_range(0, 500);
            stamp   = sim_now;
        end
        else if (pick < 95)
            op = OP_REMOVE;
        else
            op = OP_UNUSED;
        send_request(op, id, interval, stamp);
        counted = (op != OP_UNUSED);
    endtask

    task automatic run_random(input int unsigned items);
        int unsigned done;
        bit          counted;

        done = 0;
        while (done < items)
        begin
            random_request(counted);
            if (counted)
                done++;
        end
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        idle_on            = 1'b1;
        hold_requests      = 0;
        cycle_count        = 0;
        sim_now            = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_ADD;
        req_ch.timer_id    = '0;
        req_ch.interval_ms = '0;
        req_ch.now_us      = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, absolute mode out of reset
        send_request(OP_TICK,   4'd0,  32'd0,        48'd0);     // empty table
        send_request(OP_ADD,    4'd0,  32'd0,        48'd0);     // zero interval
        send_request(OP_ADD,    4'd0,  32'd7,        48'd0);     // already armed
        send_request(OP_ADD,    4'd15, INTERVAL_MAX, 48'd0);
        send_request(OP_ADD,    4'd5,  32'd1,        48'd0);
        send_request(OP_TICK,   4'd0,  32'd0,        48'd0);     // nothing elapsed
        send_request(OP_TICK,   4'd0,  32'd0,        48'd1);
        send_request(OP_TICK,   4'd0,  32'd0,        48'd1000);  // exactly one period
        send_request(OP_TICK,   4'd0,  32'd0,        48'd1500);  // start advances
        send_request(OP_TICK,   4'd0,  32'd0,        48'd2500);
        send_request(OP_TICK,   4'd0,  32'd0,        48'd10000); // more than two periods
        send_request(OP_TICK,   4'd0,  32'd0,        48'd5000);  // clock went back
        send_request(OP_REMOVE, 4'd5,  32'd0,        48'd0);
        send_request(OP_REMOVE, 4'd5,  32'd0,        48'd0);     // already idle
        send_request(OP_REMOVE, 4'd10, 32'd0,        48'd0);     // never armed
        send_request(OP_UNUSED, 4'd9,  INTERVAL_MAX, TIME_MAX);  // ignored
        send_request(OP_TICK,   4'd0,  32'd0,        TIME_MAX);
        send_request(OP_TICK,   4'd0,  32'd0,        48'd0);     // wraps around
        send_request(OP_ADD,    4'd10, 32'd2,        48'd0);
        send_request(OP_TICK,   4'd0,  32'd0,        TIME_HALF);
        send_request(OP_TICK,   4'd0,  32'd0,        48'h83E7_FFFF_FC19); // max period + 1
        send_request(OP_REMOVE, 4'd0,  32'd0,        48'd0);
        send_request(OP_REMOVE, 4'd15, 32'd0,        48'd0);
        send_request(OP_REMOVE, 4'd10, 32'd0,        48'd0);
        wait_drained();

        // relative mode, clock starting just below the wrap point
        write_mode(MODE_RELATIVE);
        sim_now = TIME_MAX - 48'd150000;
        run_random(28);
        wait_drained();

        // long response hold while requests keep coming
        idle_on = 1'b0;
        hold_requests++;
        run_random(10);
        idle_on = 1'b1;
        wait_drained();

        write_mode(MODE_ABSOLUTE);
        run_random(26);
        wait_drained();

        // closing stretch without any idling
        write_mode(MODE_RELATIVE);
        idle_on = 1'b0;
        run_random(20);
        wait_drained();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ptt_pkg.sv
rtl/core/ptt_req_if.sv
rtl/core/ptt_rsp_if.sv
rtl/core/periodic_timer_table.sv
tb/timer_result_checker.sv
tb/tb_periodic_timer_table.sv
